### hdl/lpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared widths, register indexes, reset values and handshake structs of the
// lookahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

  localparam int unsigned LOOKAHEAD_DEF   = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned LVL_W      = 24;  // threshold, envelope, peak, smoothing
  localparam int unsigned COEF_W     = 26;  // biquad taps, multiplier port a
  localparam int unsigned HIST_W     = 32;  // biquad history, multiplier port b
  localparam int unsigned GAIN_W     = 25;  // q1.24 gain up to 1.0
  localparam int unsigned PROD_W     = COEF_W + HIST_W;
  localparam int unsigned ACC_W      = PROD_W + 3;
  localparam int unsigned HIST_DEPTH = 8;   // two channels of four taps
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COEF_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << LVL_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_B0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_B1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_B2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_A1  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHELF_A2  = 3'd7;

  localparam logic [LVL_W-1:0]         THRESHOLD_RST = 24'd8388608;
  localparam logic [LVL_W-1:0]         ATTACK_RST    = 24'd0;
  localparam logic [LVL_W-1:0]         RELEASE_RST   = 24'd16760000;
  localparam logic signed [COEF_W-1:0] SHELF_B0_RST  = 26'sd4194304;

  typedef struct packed {
    logic             start;
    logic [LVL_W-1:0] num;
    logic [LVL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] quot;
  } div_rsp_t;

  function automatic int unsigned addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### hdl/lpl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_if
// Valid/ready channels of the limiter: stereo input frame and output frame.
// ----------------------------------------------------------------------------
interface lpl_in_if import lpl_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          single_channel;

  modport source (output valid, left_in, right_in, single_channel, input ready);
  modport sink   (input valid, left_in, right_in, single_channel, output ready);
endinterface

interface lpl_out_if import lpl_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

### hdl/lookahead_peak_limiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_core
// Stereo lookahead peak limiter: delay line and biquad history in rams, one
// shared 26x32 multiplier, one-pole envelope and an iterative gain divider.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   left_in, right_in, single_channel
//   out_o    out  valid/ready   left_out, right_out
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// an item takes longer in stereo than in mono, and longer with limiting than
// without; set by the biquad pass per channel through the history ram and
// the multiplier, and the wait on the divider.
// reset clears delay line and history through a fill flag and valid bits;
// no clearing pass. a stalled output holds the result register; the next
// item is taken and worked on meanwhile, then waits in S_PUSH.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_core import lpl_pkg::*; #(
  parameter int unsigned LOOKAHEAD_SAMPLES = LOOKAHEAD_DEF,
  parameter int unsigned SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lpl_in_if.sink                in_i,
  lpl_out_if.source             out_o
);

  localparam int unsigned AW = addr_w(LOOKAHEAD_SAMPLES);
  localparam int unsigned SB = SAMPLE_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HRD  = 4'd1;
  localparam logic [3:0] S_MAC  = 4'd2;
  localparam logic [3:0] S_HWR  = 4'd3;
  localparam logic [3:0] S_ENV  = 4'd4;
  localparam logic [3:0] S_GAIN = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;

  localparam logic signed [ACC_W-1:0]  Y_MAX = (ACC_W'(1) <<< 31) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  Y_MIN = -(ACC_W'(1) <<< 31);
  localparam logic signed [PROD_W-1:0] O_MAX = (PROD_W'(1) <<< (SB - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] O_MIN = -(PROD_W'(1) <<< (SB - 1));

  // configuration registers
  logic [LVL_W-1:0]         thr_q, att_q, rel_q;
  logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

  // control
  logic [3:0]    state_q, state_d;
  logic [2:0]    step_q, step_d;
  logic          ch_q, mono_q, dvalid_q, filled_q;
  logic [AW-1:0] ptr_q;
  logic          out_valid_q;
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic          hist_rvld_q;
  logic [LVL_W-1:0] env_q;

  // datapath
  logic signed [HIST_W-1:0] xl_q, xr_q, y_q;
  logic signed [HIST_W-1:0] h_q [4];
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_sub_q;
  logic [LVL_W-1:0]         peak_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [SB-1:0]     lres_q, rres_q, out_l_q, out_r_q;

  logic accept, push;
  assign accept = (state_q == S_IDLE) && in_i.valid;
  assign push   = (state_q == S_PUSH) && (!out_valid_q || out_o.ready);

  // delay line ram, left in the low half
  logic signed [SB-1:0] xr_in;
  logic [2*SB-1:0]      dly_rdata;
  logic [AW-1:0]        ptr_nxt;
  logic                 ptr_wrap;

  assign xr_in    = in_i.single_channel ? in_i.left_in : in_i.right_in;
  assign ptr_wrap = (ptr_q == AW'(LOOKAHEAD_SAMPLES - 1));
  assign ptr_nxt  = ptr_wrap ? '0 : ptr_q + AW'(1);

  lpl_ram #(
    .WIDTH (2 * SB),
    .DEPTH (LOOKAHEAD_SAMPLES)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (ptr_q),
    .wdata_i ({xr_in, in_i.left_in}),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (dly_rdata)
  );

  // biquad history ram: x1, x2, y1, y2 per channel
  logic [2:0]              hist_raddr, hist_waddr;
  logic                    hist_re, hist_we;
  logic [HIST_W-1:0]       hist_rdata, hist_wdata;
  logic signed [HIST_W-1:0] hist_rd, x_sel;

  assign x_sel      = ch_q ? xr_q : xl_q;
  assign hist_raddr = {ch_q, step_q[1:0]};
  assign hist_re    = (state_q == S_HRD) && !step_q[2];
  assign hist_we    = (state_q == S_HWR);
  assign hist_rd    = hist_rvld_q ? signed'(hist_rdata) : '0;

  always_comb begin
    hist_waddr = {ch_q, 2'd1};
    hist_wdata = h_q[0];
    case (step_q[1:0])
      2'd0: begin
        hist_waddr = {ch_q, 2'd1};
        hist_wdata = h_q[0];
      end
      2'd1: begin
        hist_waddr = {ch_q, 2'd0};
        hist_wdata = x_sel;
      end
      2'd2: begin
        hist_waddr = {ch_q, 2'd3};
        hist_wdata = h_q[2];
      end
      default: begin
        hist_waddr = {ch_q, 2'd2};
        hist_wdata = y_q;
      end
    endcase
  end

  lpl_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // shared multiplier operand select
  logic [LVL_W-1:0]          coef;
  logic [GAIN_W-1:0]         one_minus;
  logic signed [HIST_W-1:0]  dl_ext, dr_ext;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [HIST_W-1:0]  mul_b;
  logic                      mul_sub;
  logic signed [PROD_W-1:0]  mul_p;

  assign coef      = (peak_q > env_q) ? att_q : rel_q;
  assign one_minus = GAIN_ONE - {1'b0, coef};
  assign dl_ext    = dvalid_q ? HIST_W'(signed'(dly_rdata[SB-1:0])) : '0;
  assign dr_ext    = dvalid_q ? HIST_W'(signed'(dly_rdata[2*SB-1:SB])) : '0;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sub = 1'b0;
    case (state_q)
      S_MAC: begin
        case (step_q)
          3'd0: begin
            mul_a = b0_q;
            mul_b = x_sel;
          end
          3'd1: begin
            mul_a = b1_q;
            mul_b = h_q[0];
          end
          3'd2: begin
            mul_a = b2_q;
            mul_b = h_q[1];
          end
          3'd3: begin
            mul_a   = a1_q;
            mul_b   = h_q[2];
            mul_sub = 1'b1;
          end
          3'd4: begin
            mul_a   = a2_q;
            mul_b   = h_q[3];
            mul_sub = 1'b1;
          end
          default: ;
        endcase
      end
      S_ENV: begin
        if (step_q == 3'd0) begin
          mul_a = signed'({2'b00, coef});
          mul_b = signed'({8'h00, env_q});
        end else begin
          mul_a = signed'({1'b0, one_minus});
          mul_b = signed'({8'h00, peak_q});
        end
      end
      S_OUT: begin
        mul_a = signed'({1'b0, gain_q});
        mul_b = (step_q == 3'd0) ? dl_ext : dr_ext;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // biquad result: round, shift by 22, saturate to 32 bits
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [HIST_W-1:0] y_sat;
  logic [HIST_W:0]          y_abs;
  logic [LVL_W-1:0]         y_mag;

  assign acc_sh = (acc_q + (ACC_W'(1) <<< 21)) >>> 22;
  assign y_sat  = (acc_sh > Y_MAX) ? signed'(32'h7FFF_FFFF) :
                  (acc_sh < Y_MIN) ? signed'(32'h8000_0000) : acc_sh[HIST_W-1:0];
  assign y_abs  = y_q[HIST_W-1] ? (HIST_W+1)'(0) - {y_q[HIST_W-1], y_q} : {1'b0, y_q};
  assign y_mag  = (|y_abs[HIST_W:LVL_W]) ? '1 : y_abs[LVL_W-1:0];

  // envelope update
  logic [ACC_W-1:0] env_sum;
  assign env_sum = acc_q + ACC_W'(prod_q) + (ACC_W'(1) << (LVL_W - 1));

  // output scaling: round, shift by 24, saturate
  logic signed [PROD_W-1:0] o_sh;
  logic signed [SB-1:0]     o_sat;

  assign o_sh  = (prod_q + (PROD_W'(1) <<< (LVL_W - 1))) >>> LVL_W;
  assign o_sat = (o_sh > O_MAX) ? O_MAX[SB-1:0] :
                 (o_sh < O_MIN) ? O_MIN[SB-1:0] : o_sh[SB-1:0];

  // gain divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start = (state_q == S_GAIN) && (env_q > thr_q);
  assign div_req.num   = thr_q;
  assign div_req.den   = env_q;

  lpl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q + 3'd1;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (accept) begin
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        if (step_q == 3'd4) begin
          state_d = S_MAC;
          step_d  = '0;
        end
      end
      S_MAC: begin
        if (step_q == 3'd5) begin
          state_d = S_HWR;
          step_d  = '0;
        end
      end
      S_HWR: begin
        if (step_q == 3'd3) begin
          step_d  = '0;
          state_d = (!ch_q && !mono_q) ? S_HRD : S_ENV;
        end
      end
      S_ENV: begin
        if (step_q == 3'd2) begin
          state_d = S_GAIN;
          step_d  = '0;
        end
      end
      S_GAIN: begin
        step_d  = '0;
        state_d = (env_q > thr_q) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        step_d = '0;
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (step_q == 3'd2) begin
          state_d = S_PUSH;
          step_d  = '0;
        end
      end
      S_PUSH: begin
        step_d = '0;
        if (push) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      ch_q        <= 1'b0;
      mono_q      <= 1'b0;
      dvalid_q    <= 1'b0;
      filled_q    <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      hist_vld_q  <= '0;
      hist_rvld_q <= 1'b0;
      env_q       <= '0;
      thr_q       <= THRESHOLD_RST;
      att_q       <= ATTACK_RST;
      rel_q       <= RELEASE_RST;
      b0_q        <= SHELF_B0_RST;
      b1_q        <= '0;
      b2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: thr_q <= cfg_data_i[LVL_W-1:0];
          REG_ATTACK:    att_q <= cfg_data_i[LVL_W-1:0];
          REG_RELEASE:   rel_q <= cfg_data_i[LVL_W-1:0];
          REG_SHELF_B0:  b0_q  <= signed'(cfg_data_i);
          REG_SHELF_B1:  b1_q  <= signed'(cfg_data_i);
          REG_SHELF_B2:  b2_q  <= signed'(cfg_data_i);
          REG_SHELF_A1:  a1_q  <= signed'(cfg_data_i);
          REG_SHELF_A2:  a2_q  <= signed'(cfg_data_i);
          default: ;
        endcase
      end
      if (accept) begin
        ch_q     <= 1'b0;
        mono_q   <= in_i.single_channel;
        dvalid_q <= filled_q;
        ptr_q    <= ptr_nxt;
        if (ptr_wrap) begin
          filled_q <= 1'b1;
        end
      end
      if (hist_re) begin
        hist_rvld_q <= hist_vld_q[hist_raddr];
      end
      if (hist_we) begin
        hist_vld_q[hist_waddr] <= 1'b1;
      end
      if (state_q == S_HWR && step_q == 3'd3 && !ch_q && !mono_q) begin
        ch_q <= 1'b1;
      end
      if (state_q == S_ENV && step_q == 3'd2) begin
        env_q <= env_sum[2*LVL_W-1:LVL_W];
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= mul_p;
    prod_sub_q <= mul_sub;
    if (accept) begin
      xl_q <= HIST_W'(in_i.left_in);
      xr_q <= HIST_W'(xr_in);
    end
    if (state_q == S_HRD && step_q != 3'd0) begin
      h_q[step_q[1:0] - 2'd1] <= hist_rd;
    end
    if (state_q == S_HRD && step_q == 3'd4) begin
      acc_q <= '0;
    end
    if (state_q == S_MAC && step_q != 3'd0) begin
      acc_q <= prod_sub_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
    if (state_q == S_HWR && step_q == 3'd0) begin
      y_q <= y_sat;
    end
    if (state_q == S_HWR && step_q == 3'd3) begin
      if (!ch_q || y_mag > peak_q) begin
        peak_q <= y_mag;
      end
    end
    if (state_q == S_ENV && step_q == 3'd1) begin
      acc_q <= ACC_W'(prod_q);
    end
    if (state_q == S_GAIN && !(env_q > thr_q)) begin
      gain_q <= GAIN_ONE;
    end
    if (state_q == S_DIV && div_rsp.done) begin
      gain_q <= {1'b0, div_rsp.quot};
    end
    if (state_q == S_OUT && step_q == 3'd1) begin
      lres_q <= o_sat;
    end
    if (state_q == S_OUT && step_q == 3'd2) begin
      rres_q <= mono_q ? '0 : o_sat;
    end
    if (push) begin
      out_l_q <= lres_q;
      out_r_q <= rres_q;
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

  // checks
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside of the gain wait");

  a_gain_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> gain_q <= GAIN_ONE)
    else $error("gain above unity");

  a_filled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |=> filled_q)
    else $error("delay line fill flag dropped");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= AW'(LOOKAHEAD_SAMPLES - 1))
    else $error("delay pointer beyond line length");

endmodule

### hdl/lpl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_ram
// Simple dual-port ram, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module lpl_ram import lpl_pkg::*; #(
  parameter int unsigned WIDTH = HIST_W,
  parameter int unsigned DEPTH = HIST_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [addr_w(DEPTH)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]            wdata_i,
  input  logic                        re_i,
  input  logic [addr_w(DEPTH)-1:0]    raddr_i,
  output logic [WIDTH-1:0]            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lpl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider for the gain, floor(num * 2^24 / den) with num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpl_div import lpl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(LVL_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LVL_W-1:0] rem_q;
  logic [LVL_W-1:0] den_q;
  logic [LVL_W-1:0] quot_q;
  logic [LVL_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, 1'b0};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(LVL_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? LVL_W'(rem_sh - {1'b0, den_q}) : rem_sh[LVL_W-1:0];
      quot_q <= {quot_q[LVL_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives stereo and mono frames into the lookahead peak limiter with random
// gaps on both handshakes and one long output stall. Each register setting
// is applied while the block is idle. A bit-exact limiter model in the
// scoreboard covers the sidechain biquads, envelope, gain and delay line.
// Every returned frame is checked in order against that model.
// ----------------------------------------------------------------------------
module testbench import lpl_pkg::*;;

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam int unsigned DEPTH       = LOOKAHEAD_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 2500;
  localparam int          HOLD_AFTER  = 300;
  localparam int          PHASE_ITEMS = 217;
  localparam int          END_WAIT    = 200;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } frame_t;

  class limiter_scoreboard;
    logic [LVL_W-1:0]          thr, atk, rel, env;
    logic signed [COEF_W-1:0]  b0, b1, b2, a1, a2;
    logic signed [SB-1:0]      line_l[DEPTH];
    logic signed [SB-1:0]      line_r[DEPTH];
    logic signed [HIST_W-1:0]  hist_l[4];
    logic signed [HIST_W-1:0]  hist_r[4];
    int unsigned               slot;
    frame_t                    due_frames[$];
    int                        errors;

    function new();
      thr = THRESHOLD_RST;
      atk = ATTACK_RST;
      rel = RELEASE_RST;
      env = '0;
      b0 = SHELF_B0_RST;
      b1 = '0;
      b2 = '0;
      a1 = '0;
      a2 = '0;
      for (int i = 0; i < DEPTH; i++) begin
        line_l[i] = '0;
        line_r[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
        hist_l[i] = '0;
        hist_r[i] = '0;
      end
      slot = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: thr = data[LVL_W-1:0];
        REG_ATTACK:    atk = data[LVL_W-1:0];
        REG_RELEASE:   rel = data[LVL_W-1:0];
        REG_SHELF_B0:  b0 = signed'(data);
        REG_SHELF_B1:  b1 = signed'(data);
        REG_SHELF_B2:  b2 = signed'(data);
        REG_SHELF_A1:  a1 = signed'(data);
        REG_SHELF_A2:  a2 = signed'(data);
        default: ;
      endcase
    endfunction

    function logic signed [HIST_W-1:0] run_shelf(bit right_side, longint x);
      logic signed [HIST_W-1:0] h[4];
      longint acc;
      longint y;
      for (int i = 0; i < 4; i++) h[i] = right_side ? hist_r[i] : hist_l[i];
      acc = longint'(b0) * x + longint'(b1) * longint'(h[0])
          + longint'(b2) * longint'(h[1]) - longint'(a1) * longint'(h[2])
          - longint'(a2) * longint'(h[3]);
      y = (acc + 64'sd2097152) >>> 22;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      h[1] = h[0];
      h[0] = HIST_W'(x);
      h[3] = h[2];
      h[2] = y[HIST_W-1:0];
      for (int i = 0; i < 4; i++) begin
        if (right_side) hist_r[i] = h[i];
        else hist_l[i] = h[i];
      end
      return y[HIST_W-1:0];
    endfunction

    function logic [LVL_W-1:0] level_of(logic signed [HIST_W-1:0] v);
      longint m;
      m = longint'(v);
      if (m < 0) m = -m;
      if (m > 64'sd16777215) m = 64'sd16777215;
      return m[LVL_W-1:0];
    endfunction

    function logic signed [SB-1:0] apply_gain(logic signed [SB-1:0] d, longint g);
      longint r;
      r = (longint'(d) * g + 64'sd8388608) >>> 24;
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return r[SB-1:0];
    endfunction

    // one frame in: advance delay line, sidechain and envelope, queue the expected frame
    function void take_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic mono);
      logic signed [SB-1:0] dl, dr, xr;
      logic [LVL_W-1:0]     peak, other, c;
      longint               e, gain;
      frame_t               f;
      dl = line_l[slot];
      dr = line_r[slot];
      xr = mono ? l : r;
      line_l[slot] = l;
      line_r[slot] = xr;
      slot = (slot + 1) % DEPTH;
      peak = level_of(run_shelf(1'b0, longint'(l)));
      if (!mono) begin
        other = level_of(run_shelf(1'b1, longint'(xr)));
        if (other > peak) peak = other;
      end
      c = (peak > env) ? atk : rel;
      e = (longint'(c) * longint'(env) + (64'sd16777216 - longint'(c)) * longint'(peak)
          + 64'sd8388608) >>> 24;
      env = e[LVL_W-1:0];
      gain = 64'sd16777216;
      if (env > thr) gain = (longint'(thr) <<< 24) / longint'(env);
      f.left = apply_gain(dl, gain);
      f.right = mono ? '0 : apply_gain(dr, gain);
      due_frames.insert(due_frames.size(), f);
    endfunction

    function void check_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
      frame_t f;
      if (due_frames.size() == 0) begin
        $error("unexpected result item: left_out %0d right_out %0d", l, r);
        errors++;
        return;
      end
      f = due_frames[0];
      due_frames.delete(0);
      if (l !== f.left) begin
        $error("left_out: expected %0d, got %0d", f.left, l);
        errors++;
      end
      if (r !== f.right) begin
        $error("right_out: expected %0d, got %0d", f.right, r);
        errors++;
      end
    endfunction

    function int pending();
      return due_frames.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    send_calm = 1'b0;
  bit                    sink_calm = 1'b0;
  int                    cycle_count = 0;
  limiter_scoreboard     sb;

  lpl_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  lpl_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  lookahead_peak_limiter_core #(
    .LOOKAHEAD_SAMPLES(DEPTH),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready)
      sb.take_frame(in_ch.left_in, in_ch.right_in, in_ch.single_channel);
    if (out_ch.valid && out_ch.ready)
      sb.check_frame(out_ch.left_out, out_ch.right_out);
  end

  task automatic push_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                            input logic mono);
    int gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_in <= l;
    in_ch.right_in <= r;
    in_ch.single_channel <= mono;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic random_frames(input int count);
    logic signed [SB-1:0] l, r;
    logic                 mono;
    int                   kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      l = SB'($urandom);
      r = SB'($urandom);
      if (kind >= 5 && kind <= 6) begin
        l = l >>> $urandom_range(4, 20);
        r = r >>> $urandom_range(4, 20);
      end else if (kind == 7) begin
        l = l[0] ? 24'sh7FFFFF : 24'sh800000;
        r = r[1] ? 24'sh7FFFFF : 24'sh800000;
      end else if (kind >= 8) begin
        l = l >>> 22;
        r = '0;
      end
      mono = ($urandom_range(0, 3) == 0);
      push_frame(l, r, mono);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [LVL_W-1:0] thr, input logic [LVL_W-1:0] atk,
                           input logic [LVL_W-1:0] rel, input logic signed [COEF_W-1:0] c0,
                           input logic signed [COEF_W-1:0] c1,
                           input logic signed [COEF_W-1:0] c2,
                           input logic signed [COEF_W-1:0] p1,
                           input logic signed [COEF_W-1:0] p2);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_ATTACK, CFG_DATA_W'(atk));
    write_reg(REG_RELEASE, CFG_DATA_W'(rel));
    write_reg(REG_SHELF_B0, c0);
    write_reg(REG_SHELF_B1, c1);
    write_reg(REG_SHELF_B2, c2);
    write_reg(REG_SHELF_A1, p1);
    write_reg(REG_SHELF_A2, p2);
    cfg_we <= 1'b0;
  endtask

  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int gap;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
      gap = sink_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      taken++;
      // long stall so the block fills up and pushes back on its input
      if (taken == HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic signed [COEF_W-1:0] f1, f2;
    sb = new();
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    in_ch.single_channel = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes, mono with right ignored
    push_frame('0, '0, 1'b0);
    push_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
    push_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
    push_frame(-24'sd1, 24'sd1, 1'b0);
    push_frame(24'sh555555, 24'shAAAAAA, 1'b0);
    push_frame(24'sh7FFFFF, '0, 1'b1);
    push_frame(24'sh800000, 24'sh7FFFFF, 1'b1);
    finish_phase();

    // hot sidechain: peak saturates, hard limiting, fast attack, slow release
    load_regs(24'd2097152, 24'd0, 24'hFFFFFF, 26'sh1FFFFFF, 26'sh2000000, '0, '0, '0);
    push_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    push_frame(24'sh800000, 24'sh800000, 1'b0);
    push_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
    push_frame(24'sh800000, 24'sh7FFFFF, 1'b1);
    push_frame('0, 24'sh7FFFFF, 1'b1);
    push_frame('0, '0, 1'b0);
    push_frame(24'sd1000, -24'sd1000, 1'b0);
    push_frame('0, '0, 1'b0);
    finish_phase();

    // threshold above the nominal range, then just above unity
    load_regs(24'hFFFFFF, 24'd0, 24'd0, 26'sh1FFFFFF, '0, '0, '0, '0);
    push_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
    push_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
    push_frame(24'sh400000, 24'sh400000, 1'b0);
    finish_phase();
    load_regs(24'd8388609, 24'd0, 24'd0, 26'sh1FFFFFF, '0, '0, '0, '0);
    push_frame(24'sh800000, 24'sh7FFFFF, 1'b0);
    push_frame(24'sh7FFFFF, 24'sh800000, 1'b1);
    push_frame(24'sh400000, 24'sh400000, 1'b0);
    finish_phase();

    // stable shelf with moderate limiting
    load_regs(LVL_W'($urandom_range(24'h300000, 24'h7FFFFF)),
              LVL_W'($urandom_range(0, 24'h400000)),
              LVL_W'($urandom_range(24'hF00000, 24'hFFFFFF)),
              26'sd6291456, -26'sd4194304, 26'sd1048576, -26'sd2516582, 26'sd419430);
    random_frames(PHASE_ITEMS);
    finish_phase();

    // zero threshold, slowest attack, instant release
    load_regs(24'd0, 24'hFFFFFF, 24'd0, 26'sd4194304, '0, '0, '0, '0);
    random_frames(PHASE_ITEMS);
    finish_phase();

    // all taps at their extremes, sidechain runs into saturation
    load_regs(24'hFFFFFF, 24'd0, 24'hFFFFFF, 26'sh2000000, 26'sh1FFFFFF, 26'sh2000000,
              26'sh1FFFFFF, 26'sh2000000);
    random_frames(PHASE_ITEMS);
    finish_phase();

    // fully random settings
    load_regs(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom), COEF_W'($urandom),
              COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
    random_frames(PHASE_ITEMS);
    finish_phase();

    // random feedforward, weak feedback
    f1 = COEF_W'($urandom);
    f2 = COEF_W'($urandom);
    f1 = f1 >>> 5;
    f2 = f2 >>> 6;
    load_regs(LVL_W'($urandom_range(0, 24'h800000)), LVL_W'($urandom), LVL_W'($urandom),
              COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom), f1, f2);
    random_frames(PHASE_ITEMS);
    finish_phase();

    // plain 2x gain sidechain, low threshold, default release
    load_regs(LVL_W'($urandom_range(24'h100000, 24'h400000)), 24'd0, RELEASE_RST,
              26'sd8388608, '0, '0, '0, '0);
    random_frames(PHASE_ITEMS);
    finish_phase();

    repeat (END_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/lpl_pkg.sv
hdl/lpl_if.sv
hdl/lpl_ram.sv
hdl/lpl_div.sv
hdl/lookahead_peak_limiter_core.sv
dv/testbench.sv
